>>> sv/wtrb_pkg.sv
`default_nettype none

package wtrb_pkg;

   localparam int unsigned BUF_WORDS_DEF  = 1024;
   localparam logic [31:0] HEADER_TAG_DEF = 32'h1000_2001;
   localparam int unsigned REC_WORDS      = 3;

   typedef enum logic [1:0] {
      FUNC_RESERVE = 2'd0,
      FUNC_WRITE   = 2'd1,
      FUNC_READ    = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_TOO_LARGE = 3'd1,
      STAT_OPEN      = 3'd2,
      STAT_OVERRUN   = 3'd3,
      STAT_EMPTY     = 3'd4,
      STAT_BAD_TAG   = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_RD0,
      S_RD1,
      S_RD2,
      S_RD3,
      S_W0,
      S_W1,
      S_W2,
      S_W3
   } seq_state_type;

endpackage

`default_nettype wire

>>> sv/wtrb_store.sv
`default_nettype none

module wtrb_store #(
   parameter int unsigned DEPTH = wtrb_pkg::BUF_WORDS_DEF,
   parameter int unsigned WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> sv/wtrb_ptr_add.sv
`default_nettype none

// pointer adder modulo twice the ring size, shared by every pointer step
module wtrb_ptr_add #(
   parameter int unsigned BUF_WORDS = wtrb_pkg::BUF_WORDS_DEF
) (
   input  wire logic [$clog2(2*BUF_WORDS)-1:0] base,
   input  wire logic [$clog2(2*BUF_WORDS)-1:0] offset,
   output logic      [$clog2(2*BUF_WORDS)-1:0] sum
);

   localparam int unsigned PW = $clog2(2*BUF_WORDS);
   localparam logic [PW:0] SPAN = (PW+1)'(2*BUF_WORDS);

   logic [PW:0] raw;

   always_comb begin
      raw = {1'b0, base} + {1'b0, offset};
      if (raw >= SPAN) begin
         sum = PW'(raw - SPAN);
      end else begin
         sum = raw[PW-1:0];
      end
   end

endmodule

`default_nettype wire

>>> sv/windowed_trace_ring_buffer.sv
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  func, cpu, window_words, data_word
// rsp_      out        rsp_valid/rsp_stall  read_word, status, committed, now_empty
//
// write item, empty read, overrun, rejected reserve end in S_IDLE; read item in S_READ
// reserve without eviction: S_W0 to S_W3; each evicted or skipped window adds a pass
// through S_RD0 to S_RD3, plus one more for the final record check, all paced by the
// single store read port; bad tag: passes for evicted windows, then the failing check
// reset (synchronous) empties the ring; store contents are not cleared
// req_stall is high while an item is in progress or a result waits under rsp_stall
`default_nettype none

module windowed_trace_ring_buffer #(
   parameter int unsigned BUF_WORDS  = wtrb_pkg::BUF_WORDS_DEF,
   parameter logic [31:0] HEADER_TAG = wtrb_pkg::HEADER_TAG_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_cpu,
   input  wire logic [10:0] req_window_words,
   input  wire logic [31:0] req_data_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_read_word,
   output logic [2:0]       rsp_status,
   output logic             rsp_committed,
   output logic             rsp_now_empty
);

   localparam int unsigned PW = $clog2(2*BUF_WORDS);
   localparam int unsigned AW = $clog2(BUF_WORDS);
   localparam int unsigned NW = (PW > 12) ? PW + 1 : 13;
   localparam logic [PW:0] BUF_P  = (PW+1)'(BUF_WORDS);
   localparam logic [PW:0] SPAN_P = (PW+1)'(2*BUF_WORDS);
   localparam logic [PW-1:0] REC_P = PW'(wtrb_pkg::REC_WORDS);
   localparam logic [NW-1:0] BUF_N = NW'(BUF_WORDS);

   function automatic logic [AW-1:0] to_idx(input logic [PW-1:0] p);
      if ({1'b0, p} >= BUF_P) begin
         return AW'({1'b0, p} - BUF_P);
      end
      return p[AW-1:0];
   endfunction

   wtrb_pkg::seq_state_type state_ff, state_in;

   logic [PW-1:0] commit_ptr_ff, commit_ptr_in;
   logic [PW-1:0] oldest_ptr_ff, oldest_ptr_in;
   logic [PW-1:0] write_ptr_ff, write_ptr_in;
   logic [10:0]   pending_ff, pending_in;
   logic [11:0]   deficit_ff, deficit_in;
   logic          skip_ff, skip_in;
   logic [31:0]   peak_cpu_ff, peak_cpu_in;
   logic [31:0]   tag_ff, tag_in;
   logic [31:0]   cpu_rd_ff, cpu_rd_in;
   logic [7:0]    cpu_req_ff, cpu_req_in;
   logic [10:0]   len_req_ff, len_req_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_word_ff, rsp_word_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic          rsp_committed_ff, rsp_committed_in;
   logic          rsp_empty_ff, rsp_empty_in;

   logic          accept;
   logic          finish;
   logic [31:0]   res_word;
   wtrb_pkg::status_type res_status;
   logic          res_committed;

   logic [PW-1:0] used;
   logic [PW-1:0] add_base, add_offset, add_sum;
   logic [PW-1:0] freed;
   logic          rec_ok;
   logic [11:0]   need;
   logic [NW-1:0] need_total;

   logic          mem_wr_en;
   logic [PW-1:0] mem_wr_ptr, mem_rd_ptr;
   logic [31:0]   mem_wr_data, mem_rd_data;

   wtrb_ptr_add #(.BUF_WORDS(BUF_WORDS)) u_ptr_add (
      .base   (add_base),
      .offset (add_offset),
      .sum    (add_sum)
   );

   wtrb_store #(.DEPTH(BUF_WORDS), .WIDTH(32)) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (to_idx(mem_wr_ptr)),
      .wr_data (mem_wr_data),
      .rd_addr (to_idx(mem_rd_ptr)),
      .rd_data (mem_rd_data)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != wtrb_pkg::S_IDLE) || (rsp_valid_ff && rsp_stall);

   always_comb begin
      if (commit_ptr_ff >= oldest_ptr_ff) begin
         used = commit_ptr_ff - oldest_ptr_ff;
      end else begin
         used = PW'({1'b0, commit_ptr_ff} + SPAN_P - {1'b0, oldest_ptr_ff});
      end
   end

   // record check at the oldest pointer; length word is on the read port
   assign rec_ok = (used >= REC_P) && (tag_ff == HEADER_TAG) &&
                   (mem_rd_data <= (32'(used) - 32'(wtrb_pkg::REC_WORDS)));
   assign freed  = mem_rd_data[PW-1:0] + REC_P;
   assign need   = {1'b0, req_window_words} + 12'(wtrb_pkg::REC_WORDS);
   assign need_total = NW'(need) + NW'(used);

   always_comb begin
      state_in      = state_ff;
      commit_ptr_in = commit_ptr_ff;
      oldest_ptr_in = oldest_ptr_ff;
      write_ptr_in  = write_ptr_ff;
      pending_in    = pending_ff;
      deficit_in    = deficit_ff;
      skip_in       = skip_ff;
      peak_cpu_in   = peak_cpu_ff;
      tag_in        = tag_ff;
      cpu_rd_in     = cpu_rd_ff;
      cpu_req_in    = cpu_req_ff;
      len_req_in    = len_req_ff;
      finish        = 1'b0;
      res_word      = '0;
      res_status    = wtrb_pkg::STAT_OK;
      res_committed = 1'b0;
      add_base      = oldest_ptr_ff;
      add_offset    = '0;
      mem_wr_en     = 1'b0;
      mem_wr_ptr    = commit_ptr_ff;
      mem_wr_data   = HEADER_TAG;
      mem_rd_ptr    = oldest_ptr_ff;

      unique case (state_ff)
         wtrb_pkg::S_IDLE: begin
            if (req_func == wtrb_pkg::FUNC_WRITE) begin
               add_base = write_ptr_ff;
            end
            add_offset = PW'(1);
            if (accept) begin
               case (req_func)
                  wtrb_pkg::FUNC_RESERVE: begin
                     cpu_req_in = req_cpu;
                     len_req_in = req_window_words;
                     peak_cpu_in = '0;
                     skip_in    = 1'b0;
                     if (pending_ff != '0) begin
                        finish     = 1'b1;
                        res_status = wtrb_pkg::STAT_OPEN;
                     end else if (NW'(need) > BUF_N) begin
                        finish     = 1'b1;
                        res_status = wtrb_pkg::STAT_TOO_LARGE;
                     end else if (need_total > BUF_N) begin
                        deficit_in = 12'(need_total - BUF_N);
                        state_in   = wtrb_pkg::S_RD0;
                     end else begin
                        state_in = wtrb_pkg::S_W0;
                     end
                  end
                  wtrb_pkg::FUNC_WRITE: begin
                     finish = 1'b1;
                     if (pending_ff == '0) begin
                        res_status = wtrb_pkg::STAT_OVERRUN;
                     end else begin
                        mem_wr_en    = 1'b1;
                        mem_wr_ptr   = write_ptr_ff;
                        mem_wr_data  = req_data_word;
                        write_ptr_in = add_sum;
                        pending_in   = pending_ff - 11'd1;
                        if (pending_ff == 11'd1) begin
                           commit_ptr_in = add_sum;
                           res_committed = 1'b1;
                        end
                     end
                  end
                  wtrb_pkg::FUNC_READ: begin
                     if (used == '0) begin
                        finish     = 1'b1;
                        res_status = wtrb_pkg::STAT_EMPTY;
                        if (pending_ff == '0) begin
                           commit_ptr_in = '0;
                           oldest_ptr_in = '0;
                           write_ptr_in  = '0;
                        end
                     end else begin
                        oldest_ptr_in = add_sum;
                        state_in      = wtrb_pkg::S_READ;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         wtrb_pkg::S_READ: begin
            finish   = 1'b1;
            res_word = mem_rd_data;
            state_in = wtrb_pkg::S_IDLE;
            if ((oldest_ptr_ff == commit_ptr_ff) && (pending_ff == '0)) begin
               commit_ptr_in = '0;
               oldest_ptr_in = '0;
               write_ptr_in  = '0;
            end
         end
         wtrb_pkg::S_RD0: begin
            state_in = wtrb_pkg::S_RD1;
         end
         wtrb_pkg::S_RD1: begin
            add_offset = PW'(1);
            mem_rd_ptr = add_sum;
            tag_in     = mem_rd_data;
            state_in   = wtrb_pkg::S_RD2;
         end
         wtrb_pkg::S_RD2: begin
            add_offset = PW'(2);
            mem_rd_ptr = add_sum;
            cpu_rd_in  = mem_rd_data;
            state_in   = wtrb_pkg::S_RD3;
         end
         wtrb_pkg::S_RD3: begin
            add_offset = freed;
            if (!skip_ff) begin
               if (!rec_ok) begin
                  finish     = 1'b1;
                  res_status = wtrb_pkg::STAT_BAD_TAG;
                  state_in   = wtrb_pkg::S_IDLE;
               end else begin
                  oldest_ptr_in = add_sum;
                  peak_cpu_in   = cpu_rd_ff;
                  state_in      = wtrb_pkg::S_RD0;
                  if (NW'(freed) >= NW'(deficit_ff)) begin
                     deficit_in = '0;
                     skip_in    = 1'b1;
                  end else begin
                     deficit_in = 12'(NW'(deficit_ff) - NW'(freed));
                  end
               end
            end else if (rec_ok && (cpu_rd_ff > peak_cpu_ff)) begin
               // keep dropping windows while the cpu number rises
               oldest_ptr_in = add_sum;
               peak_cpu_in   = cpu_rd_ff;
               state_in      = wtrb_pkg::S_RD0;
            end else begin
               state_in = wtrb_pkg::S_W0;
            end
         end
         wtrb_pkg::S_W0: begin
            mem_wr_en   = 1'b1;
            mem_wr_ptr  = commit_ptr_ff;
            mem_wr_data = HEADER_TAG;
            state_in    = wtrb_pkg::S_W1;
         end
         wtrb_pkg::S_W1: begin
            add_base    = commit_ptr_ff;
            add_offset  = PW'(1);
            mem_wr_en   = 1'b1;
            mem_wr_ptr  = add_sum;
            mem_wr_data = 32'(cpu_req_ff);
            state_in    = wtrb_pkg::S_W2;
         end
         wtrb_pkg::S_W2: begin
            add_base    = commit_ptr_ff;
            add_offset  = PW'(2);
            mem_wr_en   = 1'b1;
            mem_wr_ptr  = add_sum;
            mem_wr_data = 32'(len_req_ff);
            state_in    = wtrb_pkg::S_W3;
         end
         wtrb_pkg::S_W3: begin
            add_base     = commit_ptr_ff;
            add_offset   = REC_P;
            write_ptr_in = add_sum;
            pending_in   = len_req_ff;
            finish       = 1'b1;
            state_in     = wtrb_pkg::S_IDLE;
            if (len_req_ff == '0) begin
               commit_ptr_in = add_sum;
               res_committed = 1'b1;
            end
         end
         default: begin
            state_in = wtrb_pkg::S_IDLE;
         end
      endcase

      if (finish && (state_ff == wtrb_pkg::S_IDLE)) begin
         state_in = wtrb_pkg::S_IDLE;
      end
   end

   always_comb begin
      rsp_word_in      = rsp_word_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_committed_in = rsp_committed_ff;
      rsp_empty_in     = rsp_empty_ff;
      if (finish) begin
         rsp_valid_in     = 1'b1;
         rsp_word_in      = res_word;
         rsp_status_in    = res_status;
         rsp_committed_in = res_committed;
         rsp_empty_in     = (commit_ptr_in == oldest_ptr_in);
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= wtrb_pkg::S_IDLE;
         commit_ptr_ff <= '0;
         oldest_ptr_ff <= '0;
         write_ptr_ff  <= '0;
         pending_ff    <= '0;
         skip_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         commit_ptr_ff <= commit_ptr_in;
         oldest_ptr_ff <= oldest_ptr_in;
         write_ptr_ff  <= write_ptr_in;
         pending_ff    <= pending_in;
         skip_ff       <= skip_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      deficit_ff       <= deficit_in;
      peak_cpu_ff      <= peak_cpu_in;
      tag_ff           <= tag_in;
      cpu_rd_ff        <= cpu_rd_in;
      cpu_req_ff       <= cpu_req_in;
      len_req_ff       <= len_req_in;
      rsp_word_ff      <= rsp_word_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_committed_ff <= rsp_committed_in;
      rsp_empty_ff     <= rsp_empty_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_word = rsp_word_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_committed = rsp_committed_ff;
   assign rsp_now_empty = rsp_empty_ff;

   // with no window open the write pointer sits on the commit pointer
   assert property (@(posedge clock) disable iff (reset)
      (pending_ff == '0) |-> (write_ptr_ff == commit_ptr_ff))
      else $error("write pointer off commit pointer with no open window");

   assert property (@(posedge clock) disable iff (reset)
      {1'b0, used} <= BUF_P)
      else $error("committed words exceed ring size");

   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_func == wtrb_pkg::FUNC_WRITE)) |=> rsp_valid_ff)
      else $error("write transfer gave no result");

   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == wtrb_pkg::S_IDLE) && !accept) |=> (state_ff == wtrb_pkg::S_IDLE))
      else $error("sequencer left idle without a transfer");

endmodule

`default_nettype wire

>>> sim/testbench.sv
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RING         = wtrb_pkg::BUF_WORDS_DEF;
   localparam int unsigned RANDOM_ITEMS = 1600;
   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam logic [1:0]  FUNC_UNDEF   = 2'd3;
   localparam int unsigned N_DIRECTED   = 25;

   typedef struct packed {
      logic [31:0]          read_word;
      wtrb_pkg::status_type status;
      logic                 committed;
      logic                 now_empty;
   } trace_result_type;

   typedef struct packed {
      logic [1:0]       func;
      logic [7:0]       cpu;
      logic [10:0]      len;
      logic [31:0]      data;
      logic             has_fixed;
      trace_result_type fixed_rsp;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = wtrb_pkg::FUNC_READ;
   logic [7:0]  req_cpu = '0;
   logic [10:0] req_window_words = '0;
   logic [31:0] req_data_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_read_word;
   logic [2:0]  rsp_status;
   logic        rsp_committed;
   logic        rsp_now_empty;

   // shadow ring state
   logic [31:0] ring_mem [0:RING-1];
   logic [10:0] commit_p = '0;
   logic [10:0] oldest_p = '0;
   logic [10:0] write_p = '0;
   logic [10:0] pending = '0;
   bit          open_w = 1'b0;

   trace_result_type results_due [$];
   directed_row_type directed_rows [0:N_DIRECTED-1];

   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int unsigned items_sent = 0;
   int unsigned cycles = 0;
   int unsigned mismatches = 0;
   int unsigned windows_committed = 0;
   int unsigned windows_dropped = 0;
   int unsigned bad_tag_reserves = 0;
   int unsigned exact_fits = 0;
   int unsigned pointer_returns = 0;

   windowed_trace_ring_buffer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_cpu          (req_cpu),
      .req_window_words (req_window_words),
      .req_data_word    (req_data_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_word    (rsp_read_word),
      .rsp_status       (rsp_status),
      .rsp_committed    (rsp_committed),
      .rsp_now_empty    (rsp_now_empty)
   );

   function automatic logic [31:0] word_at(input logic [10:0] p);
      return ring_mem[p % RING];
   endfunction

   // a whole record at the oldest pointer, inside the committed words
   function automatic bit record_fits();
      logic [10:0] used;
      used = commit_p - oldest_p;
      if (used < wtrb_pkg::REC_WORDS) return 1'b0;
      if (word_at(oldest_p) != wtrb_pkg::HEADER_TAG_DEF) return 1'b0;
      return word_at(oldest_p + 11'd2) <= used - wtrb_pkg::REC_WORDS;
   endfunction

   function automatic trace_result_type trace_ring_step(input logic [1:0] f,
         input logic [7:0] c, input logic [10:0] w, input logic [31:0] d);
      trace_result_type r;
      int unsigned      need;
      int unsigned      free_words;
      int unsigned      deficit;
      int unsigned      freed;
      logic [31:0]      peak_cpu;
      bit               bad;
      r = '0;
      r.status = wtrb_pkg::STAT_OK;
      peak_cpu = '0;
      bad = 1'b0;
      if (f == wtrb_pkg::FUNC_RESERVE) begin
         need = w + wtrb_pkg::REC_WORDS;
         if (open_w) begin
            r.status = wtrb_pkg::STAT_OPEN;
         end else if (need > RING) begin
            r.status = wtrb_pkg::STAT_TOO_LARGE;
         end else begin
            free_words = RING - 11'(commit_p - oldest_p);
            if (need == free_words) exact_fits++;
            if (need > free_words) begin
               deficit = need - free_words;
               while (deficit != 0 && !bad) begin
                  if (!record_fits()) begin
                     bad = 1'b1;
                  end else begin
                     freed = wtrb_pkg::REC_WORDS + word_at(oldest_p + 11'd2);
                     peak_cpu = word_at(oldest_p + 11'd1);
                     oldest_p = oldest_p + 11'(freed);
                     deficit = (freed >= deficit) ? 0 : deficit - freed;
                     windows_dropped++;
                  end
               end
               // rising-cpu skip, never past committed data
               while (!bad && oldest_p != commit_p && record_fits() &&
                      word_at(oldest_p + 11'd1) > peak_cpu) begin
                  peak_cpu = word_at(oldest_p + 11'd1);
                  oldest_p = oldest_p +
                             11'(wtrb_pkg::REC_WORDS + word_at(oldest_p + 11'd2));
                  windows_dropped++;
               end
            end
            if (bad) begin
               r.status = wtrb_pkg::STAT_BAD_TAG;
               bad_tag_reserves++;
            end else begin
               ring_mem[commit_p % RING] = wtrb_pkg::HEADER_TAG_DEF;
               ring_mem[11'(commit_p + 11'd1) % RING] = {24'd0, c};
               ring_mem[11'(commit_p + 11'd2) % RING] = {21'd0, w};
               write_p = commit_p + 11'(wtrb_pkg::REC_WORDS);
               pending = w;
               if (w == 0) begin
                  commit_p = write_p;
                  r.committed = 1'b1;
                  windows_committed++;
               end else begin
                  open_w = 1'b1;
               end
            end
         end
      end else if (f == wtrb_pkg::FUNC_WRITE) begin
         if (!open_w || pending == 0) begin
            r.status = wtrb_pkg::STAT_OVERRUN;
         end else begin
            ring_mem[write_p % RING] = d;
            write_p = write_p + 11'd1;
            pending = pending - 11'd1;
            if (pending == 0) begin
               commit_p = write_p;
               open_w = 1'b0;
               r.committed = 1'b1;
               windows_committed++;
            end
         end
      end else if (f == wtrb_pkg::FUNC_READ) begin
         if (commit_p == oldest_p) begin
            r.status = wtrb_pkg::STAT_EMPTY;
         end else begin
            r.read_word = word_at(oldest_p);
            oldest_p = oldest_p + 11'd1;
         end
         if (oldest_p == commit_p && !open_w) begin
            if (commit_p != 0) pointer_returns++;
            oldest_p = '0;
            commit_p = '0;
            write_p = '0;
         end
      end
      r.now_empty = (commit_p == oldest_p);
      return r;
   endfunction

   task automatic send_item(input logic [1:0] f, input logic [7:0] c, input logic [10:0] w,
                            input logic [31:0] d, input bit has_fixed,
                            input trace_result_type fixed_rsp);
      trace_result_type predicted;
      bit               lowered;
      lowered = 1'b0;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         if (!lowered) begin
            req_valid <= 1'b0;
            lowered = 1'b1;
         end
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_cpu <= c;
      req_window_words <= w;
      req_data_word <= d;
      do @(posedge clock); while (req_stall);
      predicted = trace_ring_step(f, c, w, d);
      results_due.push_back(has_fixed ? fixed_rsp : predicted);
      if (f != FUNC_UNDEF) items_sent++;
   endtask

   function automatic logic [31:0] trace_data();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 5) return wtrb_pkg::HEADER_TAG_DEF;
      if (sel < 10) return $urandom_range(0, 1100);
      return $urandom;
   endfunction

   task automatic send_noise();
      int          sel;
      logic [10:0] w;
      sel = $urandom_range(0, 99);
      if (sel < 55) w = 11'($urandom_range(0, 30));
      else if (sel < 75) w = 11'($urandom_range(1022, 1024));
      else if (sel < 80) w = 11'($urandom_range(31, 1021));
      else w = 11'($urandom_range(0, 1024));
      send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), w, $urandom, 1'b0, '0);
   endtask

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, results_due.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      trace_result_type got;
      trace_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_read_word, wtrb_pkg::status_type'(rsp_status), rsp_committed,
                 rsp_now_empty};
         if (results_due.size() == 0) begin
            $display("%0t: result with nothing expected, actual %h", $time, got);
            mismatches++;
         end else begin
            want = results_due.pop_front();
            if (got.read_word !== want.read_word) begin
               $display("%0t: read_word expected %h actual %h", $time, want.read_word,
                        got.read_word);
               mismatches++;
            end
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
               mismatches++;
            end
            if (got.committed !== want.committed) begin
               $display("%0t: committed expected %b actual %b", $time, want.committed,
                        got.committed);
               mismatches++;
            end
            if (got.now_empty !== want.now_empty) begin
               $display("%0t: now_empty expected %b actual %b", $time, want.now_empty,
                        got.now_empty);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int          pick;
      int          n;
      int          sel;
      int          free_now;
      int unsigned used;
      logic [10:0] len;
      logic [7:0]  cpu_run;
      logic [7:0]  c;

      foreach (ring_mem[i]) ring_mem[i] = '0;
      cpu_run = '0;

      directed_rows = '{
         '{wtrb_pkg::FUNC_READ, 8'h00, 11'd0, 32'h0, 1'b1,
           '{32'd0, wtrb_pkg::STAT_EMPTY, 1'b0, 1'b1}},
         '{wtrb_pkg::FUNC_WRITE, 8'h00, 11'd0, 32'hDEAD_BEEF, 1'b1,
           '{32'd0, wtrb_pkg::STAT_OVERRUN, 1'b0, 1'b1}},
         '{FUNC_UNDEF, 8'h00, 11'd0, 32'h0, 1'b1,
           '{32'd0, wtrb_pkg::STAT_OK, 1'b0, 1'b1}},
         '{wtrb_pkg::FUNC_RESERVE, 8'h55, 11'd1024, 32'h0, 1'b1,
           '{32'd0, wtrb_pkg::STAT_TOO_LARGE, 1'b0, 1'b1}},
         '{wtrb_pkg::FUNC_RESERVE, 8'hAA, 11'd1022, 32'h0, 1'b1,
           '{32'd0, wtrb_pkg::STAT_TOO_LARGE, 1'b0, 1'b1}},
         // zero-length window commits on the reserve itself
         '{wtrb_pkg::FUNC_RESERVE, 8'hFF, 11'd0, 32'h0, 1'b1,
           '{32'd0, wtrb_pkg::STAT_OK, 1'b1, 1'b0}},
         '{wtrb_pkg::FUNC_RESERVE, 8'h00, 11'd2, 32'h0, 1'b0, '0},
         '{wtrb_pkg::FUNC_RESERVE, 8'h09, 11'd5, 32'h0, 1'b1,
           '{32'd0, wtrb_pkg::STAT_OPEN, 1'b0, 1'b0}},
         '{wtrb_pkg::FUNC_WRITE, 8'h00, 11'd0, 32'hFFFF_FFFF, 1'b0, '0},
         '{wtrb_pkg::FUNC_WRITE, 8'h00, 11'd0, 32'h0, 1'b0, '0},
         '{wtrb_pkg::FUNC_WRITE, 8'h00, 11'd0, 32'h1234_5678, 1'b1,
           '{32'd0, wtrb_pkg::STAT_OVERRUN, 1'b0, 1'b0}},
         '{wtrb_pkg::FUNC_READ, 8'h00, 11'd0, 32'h0, 1'b0, '0},
         '{wtrb_pkg::FUNC_READ, 8'h00, 11'd0, 32'h0, 1'b0, '0},
         '{wtrb_pkg::FUNC_READ, 8'h00, 11'd0, 32'h0, 1'b0, '0},
         '{wtrb_pkg::FUNC_READ, 8'h00, 11'd0, 32'h0, 1'b0, '0},
         '{wtrb_pkg::FUNC_READ, 8'h00, 11'd0, 32'h0, 1'b0, '0},
         '{wtrb_pkg::FUNC_READ, 8'h00, 11'd0, 32'h0, 1'b0, '0},
         '{wtrb_pkg::FUNC_READ, 8'h00, 11'd0, 32'h0, 1'b0, '0},
         // last committed word: ring empties and pointers go back to zero
         '{wtrb_pkg::FUNC_READ, 8'h00, 11'd0, 32'h0, 1'b0, '0},
         '{wtrb_pkg::FUNC_READ, 8'h00, 11'd0, 32'h0, 1'b1,
           '{32'd0, wtrb_pkg::STAT_EMPTY, 1'b0, 1'b1}},
         '{wtrb_pkg::FUNC_RESERVE, 8'h7F, 11'd1, 32'h0, 1'b0, '0},
         '{FUNC_UNDEF, 8'hFF, 11'd7, 32'hFFFF_FFFF, 1'b1,
           '{32'd0, wtrb_pkg::STAT_OK, 1'b0, 1'b1}},
         '{wtrb_pkg::FUNC_READ, 8'h00, 11'd0, 32'h0, 1'b1,
           '{32'd0, wtrb_pkg::STAT_EMPTY, 1'b0, 1'b1}},
         '{wtrb_pkg::FUNC_WRITE, 8'h00, 11'd0, wtrb_pkg::HEADER_TAG_DEF, 1'b0, '0},
         '{wtrb_pkg::FUNC_READ, 8'h00, 11'd0, 32'h0, 1'b0, '0}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].func, directed_rows[i].cpu, directed_rows[i].len,
                   directed_rows[i].data, directed_rows[i].has_fixed,
                   directed_rows[i].fixed_rsp);

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         case (items_sent * 5 / RANDOM_ITEMS)
            1: begin
               send_idle_pct = 47;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 47;
            end
            3: begin
               send_idle_pct = 8;
               rsp_stall_pct = 8;
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         pick = $urandom_range(0, 99);
         used = 11'(commit_p - oldest_p);
         if (open_w) begin
            // a window opened by stray traffic gets finished first
            while (open_w && pending != 0)
               send_item(wtrb_pkg::FUNC_WRITE, 8'h00, 11'd0, trace_data(), 1'b0, '0);
         end else if (pick < 62) begin
            free_now = RING - used;
            sel = $urandom_range(0, 99);
            if (pick >= 55 && free_now >= 3 && free_now <= 303) len = 11'(free_now - 3);
            else if (sel < 85) len = 11'($urandom_range(0, 16));
            else if (sel < 97) len = 11'($urandom_range(17, 120));
            else len = 11'($urandom_range(121, 1021));
            if ($urandom_range(0, 1) == 1) begin
               cpu_run = cpu_run + 8'($urandom_range(1, 30));
               c = cpu_run;
            end else begin
               c = 8'($urandom_range(0, 255));
            end
            send_item(wtrb_pkg::FUNC_RESERVE, c, len, $urandom, 1'b0, '0);
            while (open_w && pending != 0) begin
               if ($urandom_range(0, 99) < 4) send_noise();
               send_item(wtrb_pkg::FUNC_WRITE, 8'($urandom_range(0, 255)), 11'd0,
                         trace_data(), 1'b0, '0);
            end
            if ($urandom_range(0, 99) < 10)
               send_item(wtrb_pkg::FUNC_WRITE, 8'h00, 11'd0, $urandom, 1'b0, '0);
         end else if (pick < 80) begin
            n = $urandom_range(1, 12);
            // drain exactly one window when the oldest record is intact
            if ($urandom_range(0, 1) == 1 && record_fits() && word_at(oldest_p + 11'd2) <= 60)
               n = wtrb_pkg::REC_WORDS + word_at(oldest_p + 11'd2);
            repeat (n) send_item(wtrb_pkg::FUNC_READ, 8'h00, 11'd0, $urandom, 1'b0, '0);
         end else if (pick < 86) begin
            n = (used <= 150) ? used + 1 : 40;
            repeat (n) send_item(wtrb_pkg::FUNC_READ, 8'h00, 11'd0, 32'h0, 1'b0, '0);
         end else begin
            repeat ($urandom_range(1, 3)) send_noise();
         end
      end

      req_valid <= 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("covered %0d random transfers after the directed rows, %0d cycles",
               items_sent, cycles);
      $display("committed %0d windows, dropped %0d, bad tags %0d, exact fits %0d, returns %0d",
               windows_committed, windows_dropped, bad_tag_reserves, exact_fits,
               pointer_returns);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire
